// ===== hw/rtl/key_click_classifier_unit_defines.svh =====
// Assertion macros for the key click classifier
`ifndef KEY_CLICK_CLASSIFIER_UNIT_DEFINES_SVH
`define KEY_CLICK_CLASSIFIER_UNIT_DEFINES_SVH

// check a consequence in the same cycle
`define KCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// check a consequence in the next cycle
`define KCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/kcc_pkg.sv =====
// Types and constants shared by the key click classifier modules
`default_nettype none
package kcc_pkg;

    localparam int LEVEL_BITS  = 6;
    localparam int HOLD_MARGIN = 10;
    localparam int HOLD_W      = 12;
    localparam int WIN_W       = 8;
    localparam int SHORT_W     = 8;
    localparam int CFG_W       = 12;
    localparam int IDX_W       = 3;

    localparam logic [HOLD_W:0] HOLD_MAX = 13'd4095;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_PRESS    = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SHORT  = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_DOUBLE = 2'd3;

    localparam logic [1:0] REG_SHORT_HOLD    = 2'd0;
    localparam logic [1:0] REG_LONG_HOLD     = 2'd1;
    localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic start_scan;
        logic tick_en;
        logic read_en;
    } dp_cmd_t;

    typedef struct packed {
        logic last_key;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/key_click_classifier_unit.sv =====
// Top level of the key click classifier: short, long and double click per key
// Read item: result registered in the cycle after accept; a new read may follow while the output is not stalled.
// Scan item: one key per cycle through the shared key update unit.
// A read result waiting at the output holds off every next item until it is taken.
// Reset clears all key state at once and loads the register defaults 3, 100 and 30.
`default_nettype none
`include "key_click_classifier_unit_defines.svh"
module key_click_classifier_unit #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // key_levels[5:0], key_index[8:6], zero fill
    input  wire logic [0:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // event_code[1:0], zero fill
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    import kcc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [1:0] event_code;

    kcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .func     (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    kcc_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_levels (s_tdata[5:0]),
        .key_index  (s_tdata[8:6]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .event_code (event_code)
    );

    assign m_tdata = {6'd0, event_code};

    `KCC_ASSERT_NEXT(a_scan_blocks, s_tvalid && s_tready && !s_tuser[0], !s_tready)
    `KCC_ASSERT_NEXT(a_read_gives_item, s_tvalid && s_tready && s_tuser[0], m_tvalid)
    `KCC_ASSERT_SAME(a_no_accept_while_full, s_tready, !(m_tvalid && !m_tready))

endmodule
`default_nettype wire

// ===== hw/rtl/kcc_datapath.sv =====
// Per-key state, shared key update unit, configuration and output register
`default_nettype none
module kcc_datapath #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kcc_pkg::dp_cmd_t            cmd,
    output kcc_pkg::dp_status_t              status,
    input  wire logic [kcc_pkg::LEVEL_BITS-1:0] key_levels,
    input  wire logic [kcc_pkg::IDX_W-1:0]   key_index,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [kcc_pkg::CFG_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       event_code
);
    import kcc_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [SHORT_W-1:0]    short_hold_reg;
    logic [HOLD_W-1:0]     long_hold_reg;
    logic [WIN_W-1:0]      dbl_win_reg;

    logic [1:0]            phase_reg [NUM_KEYS];
    logic [HOLD_W-1:0]     hold_reg  [NUM_KEYS];
    logic [WIN_W-1:0]      win_reg   [NUM_KEYS];
    logic [1:0]            pend_reg  [NUM_KEYS];

    logic [LEVEL_BITS-1:0] levels_reg;
    logic [KW-1:0]         key_cnt_reg;
    logic [KW-1:0]         key_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            out_code_reg;
    logic [1:0]            out_code_next;

    logic [NUM_KEYS-1:0]   pressed_vec;
    logic                  pressed;
    logic [3:0]            ki_m1;
    logic [KW-1:0]         rd_addr;
    logic [KW-1:0]         addr;
    logic                  idx_ok;

    logic [1:0]            phase_next;
    logic [HOLD_W-1:0]     hold_next;
    logic [WIN_W-1:0]      win_next;
    logic [1:0]            pend_next;

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++) begin : g_press
            if (g < LEVEL_BITS) begin : g_pin
                assign pressed_vec[g] = ~levels_reg[g];
            end else begin : g_nopin
                assign pressed_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign pressed = pressed_vec[key_cnt_reg];
    assign ki_m1   = {1'b0, key_index} - 4'd1;
    assign rd_addr = ki_m1[KW-1:0];
    assign addr    = cmd.tick_en ? key_cnt_reg : rd_addr;
    assign idx_ok  = (key_index != '0) && ({2'b00, key_index} <= 5'(NUM_KEYS));

    // key update for one tick
    always_comb
    begin
        logic [WIN_W-1:0]  win_dec;
        logic [HOLD_W:0]   cnt_inc;
        logic [HOLD_W:0]   cnt_lim;
        phase_next = phase_reg[addr];
        hold_next  = hold_reg[addr];
        win_dec    = win_reg[addr];
        pend_next  = pend_reg[addr];
        cnt_inc    = {1'b0, hold_reg[addr]} + 13'd1;
        cnt_lim    = {1'b0, long_hold_reg} + 13'(HOLD_MARGIN);

        if (win_dec != '0)
        begin
            win_dec = win_dec - 8'd1;
            if (win_dec == '0)
            begin
                pend_next = EV_SHORT;
            end
        end
        win_next = win_dec;

        case (phase_reg[addr])
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESS;
                    hold_next  = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESS:
            begin
                if (pressed)
                begin
                    if (cnt_inc > cnt_lim)
                    begin
                        cnt_inc = {1'b0, long_hold_reg} + 13'd1;
                    end
                    if (cnt_inc > HOLD_MAX)
                    begin
                        cnt_inc = HOLD_MAX;
                    end
                    hold_next = cnt_inc[HOLD_W-1:0];
                end
                else
                begin
                    if (hold_reg[addr] >= long_hold_reg)
                    begin
                        pend_next = EV_LONG;
                        win_next  = '0;
                    end
                    else if (hold_reg[addr] >= {4'd0, short_hold_reg})
                    begin
                        if (win_dec != '0)
                        begin
                            pend_next = EV_DOUBLE;
                            win_next  = '0;
                        end
                        else
                        begin
                            win_next = dbl_win_reg;
                        end
                    end
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_cnt_next = key_cnt_reg;
        if (cmd.start_scan)
        begin
            key_cnt_next = '0;
        end
        else if (cmd.tick_en)
        begin
            key_cnt_next = key_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.read_en)
        begin
            out_valid_next = 1'b1;
            out_code_next  = idx_ok ? pend_reg[addr] : EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_hold_reg <= 8'd3;
            long_hold_reg  <= 12'd100;
            dbl_win_reg    <= 8'd30;
            key_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                hold_reg[i]  <= '0;
                win_reg[i]   <= '0;
                pend_reg[i]  <= EV_NONE;
            end
        end
        else
        begin
            key_cnt_reg   <= key_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHORT_HOLD:    short_hold_reg <= cfg_data[SHORT_W-1:0];
                    REG_LONG_HOLD:     long_hold_reg  <= cfg_data;
                    REG_DOUBLE_WINDOW: dbl_win_reg    <= cfg_data[WIN_W-1:0];
                    default:           ;
                endcase
            end
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                if (cmd.tick_en && (key_cnt_reg == KW'(i)))
                begin
                    phase_reg[i] <= phase_next;
                    hold_reg[i]  <= hold_next;
                    win_reg[i]   <= win_next;
                    pend_reg[i]  <= pend_next;
                end
                else if (cmd.read_en && idx_ok && (rd_addr == KW'(i)))
                begin
                    pend_reg[i] <= EV_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
        if (cmd.start_scan)
        begin
            levels_reg <= key_levels;
        end
    end

    assign status.last_key = (key_cnt_reg == KW'(NUM_KEYS - 1));
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign event_code      = out_code_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/kcc_ctrl.sv =====
// Controller state machine sequencing scans and reads
`default_nettype none
module kcc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                func,
    input  wire kcc_pkg::dp_status_t status,
    output kcc_pkg::dp_cmd_t         cmd
);
    import kcc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE) && !status.out_busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !func)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_key)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.start_scan = accept && !func;
    assign cmd.read_en    = accept && func;
    assign cmd.tick_en    = (state_reg == ST_SCAN);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the key click classifier: scan ticks, reads and checked events
`timescale 1ns / 100ps
module tb;
    import kcc_pkg::*;

    localparam int NUM_KEYS = 6;
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int MAX_REPORTS = 10;
    localparam int QUIET_CYCLES = 3 * (NUM_KEYS + 1) + 4;
    localparam int CYCLE_LIMIT = 1_000_000;

    class click_scoreboard;
        logic [7:0]  short_ticks;
        logic [11:0] long_ticks;
        logic [7:0]  window_ticks;
        logic [1:0]  phase_q [NUM_KEYS];
        logic [11:0] held_q [NUM_KEYS];
        logic [7:0]  window_q [NUM_KEYS];
        logic [1:0]  latched_q [NUM_KEYS];
        logic [1:0]  pending_codes [$];
        int errors;
        int checked;
        int scans;
        int reads;
        int seen [4];

        function new();
            short_ticks = 8'd3;
            long_ticks = 12'd100;
            window_ticks = 8'd30;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                phase_q[k] = PH_IDLE;
                held_q[k] = '0;
                window_q[k] = '0;
                latched_q[k] = EV_NONE;
            end
            errors = 0;
            checked = 0;
            scans = 0;
            reads = 0;
            for (int c = 0; c < 4; c++)
                seen[c] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] value);
            if (idx == REG_SHORT_HOLD)
                short_ticks = value[7:0];
            else if (idx == REG_LONG_HOLD)
                long_ticks = value;
            else if (idx == REG_DOUBLE_WINDOW)
                window_ticks = value[7:0];
        endfunction

        function void advance_key(int k, bit down);
            int nxt;
            if (window_q[k] != 0)
            begin
                window_q[k] = window_q[k] - 8'd1;
                if (window_q[k] == 0)
                    latched_q[k] = EV_SHORT;
            end
            case (phase_q[k])
                PH_IDLE:
                begin
                    if (down)
                        phase_q[k] = PH_DEBOUNCE;
                end
                PH_DEBOUNCE:
                begin
                    if (down)
                    begin
                        phase_q[k] = PH_PRESS;
                        held_q[k] = '0;
                    end
                    else
                    begin
                        phase_q[k] = PH_IDLE;
                    end
                end
                PH_PRESS:
                begin
                    if (down)
                    begin
                        nxt = held_q[k] + 1;
                        if (nxt > long_ticks + HOLD_MARGIN)
                            nxt = long_ticks + 1;
                        if (nxt > HOLD_MAX)
                            nxt = HOLD_MAX;
                        held_q[k] = nxt[11:0];
                    end
                    else
                    begin
                        if (held_q[k] >= long_ticks)
                        begin
                            latched_q[k] = EV_LONG;
                            window_q[k] = '0;
                        end
                        else if (held_q[k] >= short_ticks)
                        begin
                            if (window_q[k] != 0)
                            begin
                                latched_q[k] = EV_DOUBLE;
                                window_q[k] = '0;
                            end
                            else
                            begin
                                window_q[k] = window_ticks;
                            end
                        end
                        phase_q[k] = PH_IDLE;
                    end
                end
                default:
                    phase_q[k] = PH_IDLE;
            endcase
        endfunction

        function void note_item(logic op, logic [5:0] levels, logic [2:0] idx);
            if (op == OP_SCAN)
            begin
                scans++;
                for (int k = 0; k < NUM_KEYS; k++)
                    advance_key(k, (k < LEVEL_BITS) ? !levels[k] : 1'b0);
            end
            else
            begin
                reads++;
                if (idx >= 1 && idx <= NUM_KEYS)
                begin
                    pending_codes.push_back(latched_q[idx - 1]);
                    latched_q[idx - 1] = EV_NONE;
                end
                else
                begin
                    pending_codes.push_back(EV_NONE);
                end
            end
        endfunction

        function void check_event(logic [7:0] data);
            logic [1:0] want;
            logic [1:0] got;
            got = data[1:0];
            if (pending_codes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected event code %0d at %0t", got, $time);
                return;
            end
            want = pending_codes.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("event code mismatch at %0t: expected %0d, got %0d",
                             $time, want, got);
            end
            else
            begin
                seen[want]++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    click_scoreboard sb = new();
    bit idling = 1'b0;
    bit gaps_on = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    bit key_down [NUM_KEYS];
    int run_left [NUM_KEYS];

    key_click_classifier_unit #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser[0], s_tdata[5:0], s_tdata[8:6]);
            if (m_tvalid && m_tready)
                sb.check_event(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic op, logic [5:0] levels, logic [2:0] idx);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, idx, levels};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic scan(logic [5:0] levels);
        send_item(OP_SCAN, levels, 3'($urandom_range(0, 7)));
    endtask

    task automatic read_key(logic [2:0] idx);
        send_item(OP_READ, 6'($urandom_range(0, 63)), idx);
    endtask

    // hold off until every event has come back and the last scan has finished
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_codes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] short_v, logic [11:0] long_v, logic [7:0] window_v);
        cfg_we <= 1'b1;
        cfg_index <= REG_SHORT_HOLD;
        cfg_data <= {4'd0, short_v};
        @(posedge clk);
        sb.set_reg(REG_SHORT_HOLD, {4'd0, short_v});
        cfg_index <= REG_LONG_HOLD;
        cfg_data <= long_v;
        @(posedge clk);
        sb.set_reg(REG_LONG_HOLD, long_v);
        cfg_index <= REG_DOUBLE_WINDOW;
        cfg_data <= {4'd0, window_v};
        @(posedge clk);
        sb.set_reg(REG_DOUBLE_WINDOW, {4'd0, window_v});
        cfg_we <= 1'b0;
    endtask

    // press length in ticks; two ticks go to debounce before the hold count starts
    function automatic int pick_press_len();
        int lg;
        int sh;
        lg = sb.long_ticks;
        sh = sb.short_ticks;
        case ($urandom_range(0, 9))
            0: return 1;
            1: return $urandom_range(2, 3);
            2, 3, 4, 5: return $urandom_range(sh, (lg > sh) ? lg - 1 : sh) + 2;
            6, 7: return $urandom_range((lg > 2) ? lg - 2 : 0, lg + 12) + 2;
            default: return $urandom_range(0, sh + 2) + 2;
        endcase
    endfunction

    function automatic int pick_release_len();
        case ($urandom_range(0, 9))
            0: return 1;
            1, 2, 3, 4: return $urandom_range(1, sb.window_ticks + 4);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic logic [2:0] pick_index();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
        return 3'($urandom_range(1, NUM_KEYS));
    endfunction

    task automatic random_items(int count);
        logic [5:0] lv;
        for (int i = 0; i < count; i++)
        begin
            idling = gaps_on && ((i / 64) % 3 != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                read_key(pick_index());
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                scan(6'($urandom_range(0, 63)));
            end
            else
            begin
                lv = '1;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        key_down[k] = !key_down[k];
                        run_left[k] = key_down[k] ? pick_press_len() : pick_release_len();
                    end
                    run_left[k]--;
                    lv[k] = !key_down[k];
                end
                scan(lv);
            end
        end
    endtask

    task automatic run_phase(logic [7:0] short_v, logic [11:0] long_v, logic [7:0] window_v,
                             int count);
        set_config(short_v, long_v, window_v);
        random_items(count);
        wait_quiet();
    endtask

    initial
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_down[k] = 1'b0;
            run_left[k] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        gaps_on = 1'b1;
        idling = 1'b1;
        read_key(3'd0);
        read_key(3'd7);
        scan(6'h3E);
        scan(6'h3F);
        repeat (5) scan(6'h00);
        scan(6'h3F);
        for (int k = 1; k <= NUM_KEYS; k++)
            read_key(3'(k));
        repeat (5) scan(6'h00);
        scan(6'h3F);
        for (int k = 1; k <= NUM_KEYS; k++)
            read_key(3'(k));
        random_items(120);
        wait_quiet();

        run_phase(8'd0, 12'd1, 8'd1, 200);
        run_phase(8'd2, 12'd8, 8'd6, 300);
        run_phase(8'd1, 12'd20, 8'd15, 350);
        run_phase(8'd0, 12'd0, 8'd0, 150);

        // hold every key well past the long threshold
        set_config(8'd255, 12'd200, 8'd255);
        repeat (230) scan(6'h00);
        scan(6'h3F);
        for (int k = 1; k <= NUM_KEYS; k++)
            read_key(3'(k));
        random_items(100);
        wait_quiet();

        gaps_on = 1'b0;
        run_phase(8'd4, 12'd10, 8'd255, 250);
        idling = 1'b0;

        if (sb.pending_codes.size() != 0)
        begin
            sb.errors++;
            $display("%0d event codes never arrived", sb.pending_codes.size());
        end
        $display("%0d scan ticks and %0d reads accepted, %0d event codes checked",
                 sb.scans, sb.reads, sb.checked);
        $display("events matched: none %0d, short %0d, long %0d, double %0d",
                 sb.seen[EV_NONE], sb.seen[EV_SHORT], sb.seen[EV_LONG], sb.seen[EV_DOUBLE]);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d failures", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kcc_pkg.sv
hw/rtl/kcc_datapath.sv
hw/rtl/kcc_ctrl.sv
hw/rtl/key_click_classifier_unit.sv
tb/tb.sv
